FILE: rtl/lphs_pkg.sv
// Package for the linear probing hash set: sizes, operation and status codes,
// request/result payload structs and the slot memory entry type.
// No dependencies; used by lphs_slot_ram and linear_probe_hash_set.
package lphs_pkg;

  // Table geometry; the index and count widths follow from the slot count
  localparam int unsigned SLOTS = 1024;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned OP_W  = 3;
  localparam int unsigned STS_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_FIND   = OP_W'(0);
  localparam logic [OP_W-1:0] OP_INSERT = OP_W'(1);
  localparam logic [OP_W-1:0] OP_REMOVE = OP_W'(2);
  localparam logic [OP_W-1:0] OP_CLEAR  = OP_W'(3);
  localparam logic [OP_W-1:0] OP_NEXT   = OP_W'(4);

  // Result status codes
  localparam logic [STS_W-1:0] ST_OK   = STS_W'(0);
  localparam logic [STS_W-1:0] ST_MISS = STS_W'(1);
  localparam logic [STS_W-1:0] ST_FULL = STS_W'(2);

  // Slot state
  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_TAKEN = 2'd1,
    MARK_STALE = 2'd2
  } mark_t;

  // Request payload
  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] start_slot;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [IDX_W-1:0] slot;
    logic [KEY_W-1:0] slot_key;
    logic [CNT_W-1:0] live_count;
    logic [CNT_W-1:0] tombstone_count;
  } out_res_t;

  // One memory word: slot state and key side by side
  typedef struct packed {
    mark_t            mark;
    logic [KEY_W-1:0] key;
  } slot_entry_t;

  // Write port control toward the slot memory
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_entry_t      data;
  } ram_wr_t;

  // Step to the next slot on the probe path, wrapping at the end
  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] at);
    logic [IDX_W-1:0] nxt;
    if (at == IDX_W'(SLOTS - 1)) begin
      nxt = '0;
    end else begin
      nxt = IDX_W'(at + 1'b1);
    end
    return nxt;
  endfunction

endpackage

FILE: rtl/linear_probe_hash_set.sv
// Hash set of 64-bit keys, open addressing with linear probing over SLOTS slots.
// Find, insert, remove: the result strobe follows the read of the last slot probed (one slot
// memory read per cycle); busy drops in the cycle the result shows, so a new request waits
// for the last one's result. Next: scans on from start_slot. Clear: result next cycle, then
// busy while the sweep empties every slot. Reset (rst_n low, synchronous) starts the same
// sweep with busy high. Results are shown for one cycle and never stalled.
module linear_probe_hash_set (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lphs_pkg::in_req_t  in_req,
  output logic               out_valid,
  output lphs_pkg::out_res_t out_res
);

  localparam int unsigned IDX_W = lphs_pkg::IDX_W;
  localparam int unsigned CNT_W = lphs_pkg::CNT_W;
  localparam int unsigned KEY_W = lphs_pkg::KEY_W;

  typedef enum logic [3:0] {
    S_SWEEP = 4'b0001,
    S_IDLE  = 4'b0010,
    S_PROBE = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      addr_r, addr_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic                  free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0]      free_addr_r, free_addr_nxt;
  logic [CNT_W-1:0]      taken_r, taken_nxt;
  logic [CNT_W-1:0]      stale_r, stale_nxt;
  lphs_pkg::in_req_t     req_r, req_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lphs_pkg::out_res_t    out_r, out_nxt;

  lphs_pkg::ram_wr_t     ram_wr;
  logic [IDX_W-1:0]      rd_addr;
  lphs_pkg::slot_entry_t rd_data;

  logic                  emit;
  logic [lphs_pkg::STS_W-1:0] res_status;
  logic [IDX_W-1:0]      res_slot;
  logic [KEY_W-1:0]      res_key;

  logic [IDX_W-1:0]      next_init;
  logic                  next_none;
  logic                  is_hit;
  logic                  is_end;
  logic                  is_full;
  logic                  can_place;
  logic [IDX_W-1:0]      place_addr;
  logic                  place_stale;
  logic [CNT_W:0]        load_sum;

  lphs_slot_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Start point of a next-taken scan
  always_comb begin
    next_none = 1'b0;
    next_init = '0;
    if (in_req.start_slot >= CNT_W'(lphs_pkg::SLOTS)) begin
      next_init = '0;
    end else if (in_req.start_slot == CNT_W'(lphs_pkg::SLOTS - 1)) begin
      next_none = 1'b1;
    end else begin
      next_init = IDX_W'(in_req.start_slot[IDX_W-1:0] + 1'b1);
    end
  end

  // Probe decisions on the slot word just read
  assign is_hit   = (rd_data.mark == lphs_pkg::MARK_TAKEN) && (rd_data.key == req_r.key);
  assign is_end   = (rd_data.mark == lphs_pkg::MARK_EMPTY) ||
                    (cnt_r == IDX_W'(lphs_pkg::SLOTS - 1));
  assign load_sum = {1'b0, taken_r} + {1'b0, stale_r};
  assign is_full  = load_sum >= (CNT_W + 1)'(lphs_pkg::SLOTS / 2);

  // First non-taken slot on the path: an earlier tombstone, else the current slot
  assign can_place   = free_vld_r || (rd_data.mark != lphs_pkg::MARK_TAKEN);
  assign place_addr  = free_vld_r ? free_addr_r : addr_r;
  assign place_stale = free_vld_r || (rd_data.mark == lphs_pkg::MARK_STALE);

  // Sequencer: sweep, accept, probe, scan
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    free_vld_nxt  = free_vld_r;
    free_addr_nxt = free_addr_r;
    taken_nxt     = taken_r;
    stale_nxt     = stale_r;
    req_nxt       = req_r;
    emit          = 1'b0;
    res_status    = lphs_pkg::ST_MISS;
    res_slot      = '0;
    res_key       = '0;
    ram_wr        = '0;
    rd_addr       = lphs_pkg::wrap_next(addr_r);

    unique case (state_r)
      S_SWEEP: begin
        // Empty one slot per cycle
        ram_wr.en        = 1'b1;
        ram_wr.addr      = addr_r;
        ram_wr.data.mark = lphs_pkg::MARK_EMPTY;
        ram_wr.data.key  = '0;
        addr_nxt         = lphs_pkg::wrap_next(addr_r);
        if (addr_r == IDX_W'(lphs_pkg::SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        rd_addr = (in_req.opcode == lphs_pkg::OP_NEXT) ? next_init
                                                        : in_req.key[IDX_W-1:0];
        if (start) begin
          req_nxt = in_req;
          case (in_req.opcode)
            lphs_pkg::OP_FIND, lphs_pkg::OP_INSERT, lphs_pkg::OP_REMOVE: begin
              addr_nxt     = in_req.key[IDX_W-1:0];
              cnt_nxt      = '0;
              free_vld_nxt = 1'b0;
              state_nxt    = S_PROBE;
            end
            lphs_pkg::OP_NEXT: begin
              if (next_none) begin
                emit = 1'b1;
              end else begin
                addr_nxt  = next_init;
                state_nxt = S_SCAN;
              end
            end
            lphs_pkg::OP_CLEAR: begin
              taken_nxt  = '0;
              stale_nxt  = '0;
              addr_nxt   = '0;
              emit       = 1'b1;
              res_status = lphs_pkg::ST_OK;
              state_nxt  = S_SWEEP;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      S_PROBE: begin
        if (is_hit) begin
          emit       = 1'b1;
          res_status = lphs_pkg::ST_OK;
          res_slot   = addr_r;
          res_key    = rd_data.key;
          state_nxt  = S_IDLE;
          // Remove leaves a tombstone
          if (req_r.opcode == lphs_pkg::OP_REMOVE) begin
            ram_wr.en        = 1'b1;
            ram_wr.addr      = addr_r;
            ram_wr.data.mark = lphs_pkg::MARK_STALE;
            ram_wr.data.key  = rd_data.key;
            if (taken_r != '0) begin
              taken_nxt = CNT_W'(taken_r - 1'b1);
            end
            stale_nxt = CNT_W'(stale_r + 1'b1);
          end
        end else if (is_end) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (req_r.opcode == lphs_pkg::OP_INSERT) begin
            if (is_full) begin
              res_status = lphs_pkg::ST_FULL;
            end else if (can_place) begin
              // Place the new key
              ram_wr.en        = 1'b1;
              ram_wr.addr      = place_addr;
              ram_wr.data.mark = lphs_pkg::MARK_TAKEN;
              ram_wr.data.key  = req_r.key;
              taken_nxt        = CNT_W'(taken_r + 1'b1);
              if (place_stale && (stale_r != '0)) begin
                stale_nxt = CNT_W'(stale_r - 1'b1);
              end
              res_status = lphs_pkg::ST_OK;
              res_slot   = place_addr;
              res_key    = req_r.key;
            end
          end
        end else begin
          // Advance along the probe path
          addr_nxt = lphs_pkg::wrap_next(addr_r);
          cnt_nxt  = IDX_W'(cnt_r + 1'b1);
          if (!free_vld_r && (rd_data.mark != lphs_pkg::MARK_TAKEN)) begin
            free_vld_nxt  = 1'b1;
            free_addr_nxt = addr_r;
          end
        end
      end

      S_SCAN: begin
        if (rd_data.mark == lphs_pkg::MARK_TAKEN) begin
          emit       = 1'b1;
          res_status = lphs_pkg::ST_OK;
          res_slot   = addr_r;
          res_key    = rd_data.key;
          state_nxt  = S_IDLE;
        end else if (addr_r == IDX_W'(lphs_pkg::SLOTS - 1)) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = lphs_pkg::wrap_next(addr_r);
        end
      end

      default: begin
        state_nxt = S_SWEEP;
        addr_nxt  = '0;
      end
    endcase

    // Build the result word
    out_valid_nxt = emit;
    out_nxt       = out_r;
    if (emit) begin
      out_nxt.status          = res_status;
      out_nxt.slot            = res_slot;
      out_nxt.slot_key        = res_key;
      out_nxt.live_count      = taken_nxt;
      out_nxt.tombstone_count = stale_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      addr_r      <= '0;
      cnt_r       <= '0;
      free_vld_r  <= 1'b0;
      taken_r     <= '0;
      stale_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      cnt_r       <= cnt_nxt;
      free_vld_r  <= free_vld_nxt;
      taken_r     <= taken_nxt;
      stale_r     <= stale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    free_addr_r <= free_addr_nxt;
    out_r       <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // Occupancy never passes half the table
  assert property (@(posedge clk) disable iff (!rst_n)
    load_sum <= (CNT_W + 1)'(lphs_pkg::SLOTS / 2))
    else $error("taken plus stale slots exceed half of the table");

  // A clear request reports empty counts in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req.opcode == lphs_pkg::OP_CLEAR)
    |=> out_valid && (out_res.live_count == '0) && (out_res.tombstone_count == '0))
    else $error("clear result missing or counts not zero");

  // A result that reports no slot carries zero slot and key
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.status != lphs_pkg::ST_OK)
    |-> (out_res.slot == '0) && (out_res.slot_key == '0))
    else $error("slot fields not zero on a miss or full result");

  // A slot update during a probe always ends the request with a result
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr.en && (state_r == S_PROBE) |=> out_valid && !busy)
    else $error("slot write in probe without a result");

endmodule

FILE: rtl/lphs_slot_ram.sv
// Slot memory of the hash set: one word per slot holding its state and key.
// One write port, one read port with registered read data.
// Depends on lphs_pkg.
module lphs_slot_ram (
  input  logic                            clk,
  input  lphs_pkg::ram_wr_t               wr,
  input  logic [lphs_pkg::IDX_W-1:0]      rd_addr,
  output lphs_pkg::slot_entry_t           rd_data
);

  lphs_pkg::slot_entry_t mem [lphs_pkg::SLOTS];
  lphs_pkg::slot_entry_t rd_data_r;

  // Write the addressed word
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
